[hw/rtl/bht_pkg.sv]
// Shared types and constants for the bone hierarchy transform block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package bht_pkg;

   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int SUM_W     = PROD_W + 3;
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic CMD_BONE  = 1'b0;
   localparam logic CMD_WORLD = 1'b1;

   typedef logic signed [WORD_W-1:0] bht_word_type;
   typedef bht_word_type [3:0] bht_row_type;
   typedef bht_row_type [3:0] bht_mat_type;

   localparam bht_word_type WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
   localparam bht_word_type WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

   typedef struct packed {
      logic         cmd;
      logic [7:0]   bone_number;
      logic [1:0]   row_number;
      bht_word_type e0;
      bht_word_type e1;
      bht_word_type e2;
      bht_word_type e3;
      logic         has_parent;
      logic [7:0]   parent_number;
   } bht_req_type;

   typedef struct packed {
      logic [7:0]   out_bone;
      logic [1:0]   out_row;
      bht_word_type g0;
      bht_word_type g1;
      bht_word_type g2;
      bht_word_type g3;
      logic         order_error;
      logic         saturated;
   } bht_rsp_type;

   // global row write, from the last lane stage into the store
   typedef struct packed {
      logic        valid;
      logic [7:0]  bone;
      logic [1:0]  row;
      bht_row_type data;
   } bht_wr_type;

   // world matrix row load
   typedef struct packed {
      logic        valid;
      logic [1:0]  row;
      bht_row_type data;
   } bht_wld_type;

   // which matrix the word in the first stage multiplies against
   typedef struct packed {
      logic       has_parent;
      logic [7:0] parent;
   } bht_sel_type;

endpackage

[hw/rtl/bone_hierarchy_transform.sv]
// Bone hierarchy transform: one global matrix row per bone word, four lanes.
// A bone word passes stages s1, s2, s3 and the result queue on its way to rsp.
// Throughput: one word per cycle while the result queue has room; a stall
// when a bone's parent is the bone of the word just before it (its row is
// still in the product stage). Reset: world matrix to identity, pipeline and
// result queue empty; the global store is not cleared.
`timescale 1ns / 1ps

module bone_hierarchy_transform
   import bht_pkg::*;
#(
   parameter int MAX_BONES = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bht_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bht_rsp_type rsp_data
);

   localparam int LIM_W = $clog2(MAX_BONES + 1);
   localparam int CMP_W = (LIM_W > 8) ? LIM_W : 8;
   localparam int CRD_W = RSP_CNT_W + 1;

   logic accept, bone_accept, hazard, room, err_in;
   logic [CRD_W-1:0] credit;
   logic [RSP_CNT_W-1:0] fifo_count;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [7:0]  s1_bone_ff, s2_bone_ff, s3_bone_ff;
   logic [1:0]  s1_row_ff, s2_row_ff, s3_row_ff;
   logic        s1_err_ff, s2_err_ff, s3_err_ff;
   bht_row_type s1_e_ff;
   bht_sel_type s1_sel_ff;

   bht_mat_type mat, col;
   wire bht_row_type g_row;
   wire [3:0]   sat_lane;
   bht_wr_type  wr;
   bht_wld_type world_wr;
   bht_rsp_type push_data;

   // results in flight or queued must always fit in the queue
   assign credit = CRD_W'(fifo_count) + CRD_W'(s1_valid_ff) + CRD_W'(s2_valid_ff)
                 + CRD_W'(s3_valid_ff);
   assign room   = credit < CRD_W'(RSP_DEPTH);
   assign hazard = req_data.cmd == CMD_BONE && req_data.has_parent && s1_valid_ff
                && s1_bone_ff == req_data.parent_number;
   assign req_stall   = !room || hazard;
   assign accept      = req_valid && !req_stall;
   assign bone_accept = accept && req_data.cmd == CMD_BONE;
   assign err_in = req_data.has_parent
                && (req_data.parent_number >= req_data.bone_number
                 || CMP_W'(req_data.parent_number) >= CMP_W'(MAX_BONES));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= bone_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (bone_accept) begin
         s1_bone_ff <= req_data.bone_number;
         s1_row_ff  <= req_data.row_number;
         s1_err_ff  <= err_in;
         s1_e_ff    <= {req_data.e3, req_data.e2, req_data.e1, req_data.e0};
         s1_sel_ff  <= {req_data.has_parent, req_data.parent_number};
      end
      s2_bone_ff <= s1_bone_ff;
      s2_row_ff  <= s1_row_ff;
      s2_err_ff  <= s1_err_ff;
      s3_bone_ff <= s2_bone_ff;
      s3_row_ff  <= s2_row_ff;
      s3_err_ff  <= s2_err_ff;
   end

   assign world_wr.valid = accept && req_data.cmd == CMD_WORLD;
   assign world_wr.row   = req_data.row_number;
   assign world_wr.data  = {req_data.e3, req_data.e2, req_data.e1, req_data.e0};

   // drop writes for bones beyond the store
   assign wr.valid = s3_valid_ff && CMP_W'(s3_bone_ff) < CMP_W'(MAX_BONES);
   assign wr.bone  = s3_bone_ff;
   assign wr.row   = s3_row_ff;
   assign wr.data  = g_row;

   bht_store #(
      .MAX_BONES (MAX_BONES),
      .FRAC_BITS (FRAC_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (bone_accept),
      .rd_parent (req_data.parent_number),
      .world_wr  (world_wr),
      .wr        (wr),
      .sel       (s1_sel_ff),
      .mat       (mat)
   );

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            col[c][k] = mat[k][c];
         end
      end
   end

   for (genvar c = 0; c < 4; c++) begin : g_lane
      bht_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .e     (s1_e_ff),
         .col   (col[c]),
         .clear (s2_err_ff),
         .g     (g_row[c]),
         .sat   (sat_lane[c])
      );
   end

   // merge the lanes into one result word
   assign push_data.out_bone    = s3_bone_ff;
   assign push_data.out_row     = s3_row_ff;
   assign push_data.g0          = g_row[0];
   assign push_data.g1          = g_row[1];
   assign push_data.g2          = g_row[2];
   assign push_data.g3          = g_row[3];
   assign push_data.order_error = s3_err_ff;
   assign push_data.saturated   = |sat_lane;

   bht_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (push_data),
      .pop       (rsp_valid && !rsp_stall),
      .valid     (rsp_valid),
      .head      (rsp_data),
      .count     (fifo_count)
   );

   a_credit: assert property (@(posedge clock) disable iff (reset)
      credit <= CRD_W'(RSP_DEPTH))
      else $error("result queue overcommitted");

   a_forward: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_sel_ff.has_parent && !s1_err_ff && s2_valid_ff)
      |-> (s2_bone_ff != s1_sel_ff.parent))
      else $error("parent row still in product stage");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_err_ff) |-> (g_row == '0 && sat_lane == '0))
      else $error("order error row not zeroed");

   a_world_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.cmd == CMD_WORLD) |=> !s1_valid_ff)
      else $error("world load entered the lanes");

endmodule

[hw/rtl/bht_lane.sv]
// One column lane: four Q16.16 products, exact sum, rounding and clamp.
// Depends on bht_pkg.
`timescale 1ns / 1ps

module bht_lane
   import bht_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  bht_row_type  e,
   input  bht_row_type  col,
   input  logic         clear,
   output bht_word_type g,
   output logic         sat
);

   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [PROD_W-1:0] prod_in [4];
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-WORD_W:0]    upper;
   logic                     over;
   bht_word_type             g_ff, g_in;
   logic                     sat_ff, sat_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = PROD_W'(e[k]) * PROD_W'(col[k]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round half up, then clamp to the word range; clear forces zero
   always_comb begin
      sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
          + SUM_W'(prod_ff[3]) + HALF;
      shifted = sum >>> FRAC_BITS;
      upper = shifted[SUM_W-1:WORD_W-1];
      over = !((&upper) || (~|upper));
      if (clear) begin
         g_in = '0;
      end else if (over) begin
         g_in = shifted[SUM_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
         g_in = shifted[WORD_W-1:0];
      end
      sat_in = over && !clear;
   end

   always_ff @(posedge clock) begin
      g_ff   <= g_in;
      sat_ff <= sat_in;
   end

   assign g   = g_ff;
   assign sat = sat_ff;

endmodule

[hw/rtl/bht_store.sv]
// Global matrix store (one memory per matrix row), world matrix and
// forwarding of rows still on their way into memory. Depends on bht_pkg.
`timescale 1ns / 1ps

module bht_store
   import bht_pkg::*;
#(
   parameter int MAX_BONES = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [7:0]  rd_parent,
   input  bht_wld_type world_wr,
   input  bht_wr_type  wr,
   input  bht_sel_type sel,
   output bht_mat_type mat
);

   localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int XW = (AW > 8) ? AW : 8;
   localparam bht_word_type ONE = WORD_W'(1) << FRAC_BITS;

   bht_row_type mem [4][MAX_BONES];
   bht_row_type rd_ff [4];
   bht_mat_type world_ff;
   bht_wr_type  wb_ff;
   logic [XW-1:0] rd_ext, wr_ext;
   logic [AW-1:0] raddr, waddr;

   assign rd_ext = XW'(rd_parent);
   assign wr_ext = XW'(wr.bone);
   assign raddr  = rd_ext[AW-1:0];
   assign waddr  = wr_ext[AW-1:0];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (wr.valid && wr.row == 2'(k)) begin
            mem[k][waddr] <= wr.data;
         end
         if (rd_en) begin
            rd_ff[k] <= mem[k][raddr];
         end
      end
   end

   // register the last write: the read that saw that edge missed it
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff.valid <= 1'b0;
      end else begin
         wb_ff <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               world_ff[i][j] <= (i == j) ? ONE : '0;
            end
         end
      end else if (world_wr.valid) begin
         world_ff[world_wr.row] <= world_wr.data;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (!sel.has_parent) begin
            mat[k] = world_ff[k];
         end else if (wr.valid && wr.row == 2'(k) && wr.bone == sel.parent) begin
            mat[k] = wr.data;
         end else if (wb_ff.valid && wb_ff.row == 2'(k) && wb_ff.bone == sel.parent) begin
            mat[k] = wb_ff.data;
         end else begin
            mat[k] = rd_ff[k];
         end
      end
   end

endmodule

[hw/rtl/bht_rsp_fifo.sv]
// Result queue between the lanes and the rsp channel.
// Depends on bht_pkg.
`timescale 1ns / 1ps

module bht_rsp_fifo
   import bht_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bht_rsp_type          push_data,
   input  logic                 pop,
   output logic                 valid,
   output bht_rsp_type          head,
   output logic [RSP_CNT_W-1:0] count
);

   bht_rsp_type          entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

[tb/sv/tb_bone_hierarchy_transform.sv]
// Self-checking bench for bone_hierarchy_transform: predicts each global row
// from its own world/global matrix copies and checks the rsp stream in order.
// Depends on bht_pkg and the bone_hierarchy_transform RTL only.
`timescale 1ns / 1ps

module tb_bone_hierarchy_transform;
   import bht_pkg::*;

   localparam int FRAC_BITS     = 16;
   localparam int DIRECTED_WORDS = 24;
   localparam int RANDOM_WORDS  = 750;
   localparam int DRAIN_CYCLES  = 20;
   localparam bht_word_type ONE  = 32'sh0001_0000;
   localparam bht_word_type HALF = 32'sh0000_8000;
   localparam logic signed [66:0] ACC_HI = 67'sd2147483647;
   localparam logic signed [66:0] ACC_LO = -67'sd2147483648;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   bht_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   bht_rsp_type rsp_data;

   bht_req_type pending_words [$];
   bht_rsp_type expected_rows [$];
   bht_mat_type world_mat;
   bht_mat_type global_mat [256];
   bit [3:0]    rows_seen [256];
   int          words_queued;
   int          words_issued;
   int          error_count;
   bit          word_taken;

   bone_hierarchy_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_error(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // one column of row * matrix: exact products, round half up, clamp
   function automatic bht_word_type mac_column(input bht_row_type lhs, input bht_mat_type rhs,
                                               input int col, output bit clamp);
      logic signed [66:0] acc;
      logic signed [66:0] a;
      logic signed [66:0] b;
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         a = $signed(lhs[k]);
         b = $signed(rhs[k][col]);
         acc = acc + a * b;
      end
      acc = acc + (67'sd1 <<< (FRAC_BITS - 1));
      acc = acc >>> FRAC_BITS;
      clamp = 1'b1;
      if (acc > ACC_HI) return WORD_MAX;
      if (acc < ACC_LO) return WORD_MIN;
      clamp = 1'b0;
      return acc[31:0];
   endfunction

   task automatic apply_word(input bht_req_type w);
      bht_row_type lhs;
      bht_row_type grow;
      bht_mat_type m;
      bht_rsp_type want;
      bit          clamp;
      bit          any_clamp;
      lhs[0] = w.e0;
      lhs[1] = w.e1;
      lhs[2] = w.e2;
      lhs[3] = w.e3;
      if (w.cmd == CMD_WORLD) begin
         world_mat[w.row_number] = lhs;
      end else begin
         grow = '0;
         any_clamp = 1'b0;
         want = '0;
         want.order_error = w.has_parent && (w.parent_number >= w.bone_number);
         if (!want.order_error) begin
            m = w.has_parent ? global_mat[w.parent_number] : world_mat;
            for (int c = 0; c < 4; c++) begin
               grow[c] = mac_column(lhs, m, c, clamp);
               any_clamp |= clamp;
            end
         end
         global_mat[w.bone_number][w.row_number] = grow;
         want.out_bone  = w.bone_number;
         want.out_row   = w.row_number;
         want.g0        = grow[0];
         want.g1        = grow[1];
         want.g2        = grow[2];
         want.g3        = grow[3];
         want.saturated = any_clamp;
         expected_rows.push_back(want);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want, input bht_rsp_type ref_row);
      if (got !== want)
         report_error($sformatf("bone %0d row %0d %s: got %h want %h",
                                ref_row.out_bone, ref_row.out_row, name, got, want));
   endtask

   task automatic check_row(input bht_rsp_type got, input bht_rsp_type want);
      check_field("out_bone", 32'(got.out_bone), 32'(want.out_bone), want);
      check_field("out_row", 32'(got.out_row), 32'(want.out_row), want);
      check_field("g0", got.g0, want.g0, want);
      check_field("g1", got.g1, want.g1, want);
      check_field("g2", got.g2, want.g2, want);
      check_field("g3", got.g3, want.g3, want);
      check_field("order_error", 32'(got.order_error), 32'(want.order_error), want);
      check_field("saturated", 32'(got.saturated), 32'(want.saturated), want);
   endtask

   function automatic int sender_idle_pct(input int n);
      case ((n / 90) % 4)
         1: return 58;
         3: return 34;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(input int n);
      case ((n / 90) % 4)
         2: return 58;
         3: return 34;
         default: return 0;
      endcase
   endfunction

   // monitor: check results first, then predict the word taken at this edge
   always @(posedge clock) begin
      word_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0)
               report_error($sformatf("unexpected result for bone %0d row %0d",
                                      rsp_data.out_bone, rsp_data.out_row));
            else
               check_row(rsp_data, expected_rows.pop_front());
         end
         if (req_valid && !req_stall) begin
            word_taken = 1'b1;
            apply_word(req_data);
         end
      end
   end

   // driver: hold a stalled word, advance once it was taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || word_taken) begin
            if (pending_words.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(words_issued)) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
               words_issued++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct(words_issued));
      end
   end

   function automatic bht_word_type rand_elem();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         return $signed($urandom_range(0, 32'h0002_8000)) - 32'sh0001_4000;
      if (pick < 85)
         return $urandom;
      case ($urandom_range(6))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return 32'sd1;
         4: return -32'sd1;
         5: return ONE;
         default: return HALF;
      endcase
   endfunction

   task automatic push_row(input logic cmd, input int bone, input int row,
                           input bht_word_type e0, input bht_word_type e1,
                           input bht_word_type e2, input bht_word_type e3,
                           input logic has_parent, input int parent);
      bht_req_type w;
      w.cmd           = cmd;
      w.bone_number   = 8'(bone);
      w.row_number    = 2'(row);
      w.e0            = e0;
      w.e1            = e1;
      w.e2            = e2;
      w.e3            = e3;
      w.has_parent    = has_parent;
      w.parent_number = 8'(parent);
      pending_words.push_back(w);
      words_queued++;
      if (cmd == CMD_BONE) rows_seen[bone][row] = 1'b1;
   endtask

   // a parent must have all four rows written since reset; -1 means root
   function automatic int pick_parent(input int bone);
      int j;
      if (bone == 0) return -1;
      if ($urandom_range(9) < 3 && rows_seen[bone - 1] == 4'hF) return bone - 1;
      for (int tries = 0; tries < 8; tries++) begin
         j = $urandom_range(0, bone - 1);
         if (rows_seen[j] == 4'hF) return j;
      end
      return -1;
   endfunction

   initial begin
      int pick;
      int nb;
      int base;
      int parent;
      int rows_out;
      int bone;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      error_count = 0;
      words_queued = 0;
      words_issued = 0;
      word_taken = 1'b0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            world_mat[i][j] = (i == j) ? ONE : '0;

      // root bone through identity world: rows pass straight through
      push_row(CMD_BONE, 0, 0, WORD_MAX, WORD_MIN, '0, 32'sd1, 1'b0, 255);
      push_row(CMD_BONE, 0, 1, -32'sd1, -ONE, ONE, HALF, 1'b0, 255);
      push_row(CMD_BONE, 0, 2, '0, '0, ONE, '0, 1'b0, 255);
      push_row(CMD_BONE, 0, 3, 32'sh1234_5678, -32'sh0ABC_DEF0, '0, ONE, 1'b0, 255);
      // child right behind its parent, with positive and negative clamping
      push_row(CMD_BONE, 1, 0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1, 0);
      push_row(CMD_BONE, 1, 1, WORD_MIN, '0, '0, '0, 1'b1, 0);
      push_row(CMD_BONE, 1, 2, '0, '0, '0, '0, 1'b1, 0);
      push_row(CMD_BONE, 1, 3, '0, '0, '0, ONE, 1'b1, 0);
      // parent equal to, above, and at the bone itself
      push_row(CMD_BONE, 2, 0, ONE, ONE, ONE, ONE, 1'b1, 2);
      push_row(CMD_BONE, 3, 1, ONE, -ONE, HALF, ONE, 1'b1, 200);
      push_row(CMD_BONE, 0, 2, ONE, ONE, ONE, ONE, 1'b1, 0);
      // world load; bone and parent fields are don't-care here
      push_row(CMD_WORLD, 255, 0, 2 * ONE, '0, '0, '0, 1'b1, 0);
      push_row(CMD_WORLD, 17, 1, '0, HALF, '0, '0, 1'b0, 255);
      push_row(CMD_WORLD, 0, 2, '0, '0, -ONE, '0, 1'b1, 255);
      push_row(CMD_WORLD, 128, 3, 10 * ONE, -3 * ONE, HALF, ONE, 1'b0, 7);
      // top bone as root: clamp both ways, round half up on both signs
      push_row(CMD_BONE, 255, 0, WORD_MAX, '0, '0, '0, 1'b0, 255);
      push_row(CMD_BONE, 255, 1, '0, 32'sd1, '0, '0, 1'b0, 255);
      push_row(CMD_BONE, 255, 2, '0, -32'sd1, '0, '0, 1'b0, 255);
      push_row(CMD_BONE, 255, 3, WORD_MIN, '0, '0, '0, 1'b0, 255);
      for (int r = 0; r < 4; r++)
         push_row(CMD_BONE, 4, r, rand_elem(), rand_elem(), rand_elem(), rand_elem(), 1'b1, 1);
      push_row(CMD_BONE, 5, 0, ONE, HALF, -ONE, ONE, 1'b1, 4);

      while (words_queued < DIRECTED_WORDS + RANDOM_WORDS) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // skeleton pass over a run of bones, now and then cut short
            nb = $urandom_range(2, 12);
            base = $urandom_range(0, 256 - nb);
            for (int b = base; b < base + nb; b++) begin
               parent = (b == base && $urandom_range(1)) ? -1 : pick_parent(b);
               rows_out = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 4;
               for (int r = 0; r < rows_out; r++)
                  push_row(CMD_BONE, b, r, rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                           parent >= 0, (parent >= 0) ? parent : $urandom_range(255));
            end
         end else if (pick < 70) begin
            if ($urandom_range(1)) begin
               for (int r = 0; r < 4; r++)
                  push_row(CMD_WORLD, $urandom_range(255), r, rand_elem(), rand_elem(),
                           rand_elem(), rand_elem(), 1'($urandom_range(1)),
                           $urandom_range(255));
            end else begin
               push_row(CMD_WORLD, $urandom_range(255), $urandom_range(3), rand_elem(),
                        rand_elem(), rand_elem(), rand_elem(), 1'($urandom_range(1)),
                        $urandom_range(255));
            end
         end else if (pick < 85) begin
            bone = $urandom_range(255);
            push_row(CMD_BONE, bone, $urandom_range(3), rand_elem(), rand_elem(), rand_elem(),
                     rand_elem(), 1'b1, $urandom_range(bone, 255));
         end else begin
            push_row(CMD_BONE, $urandom_range(255), $urandom_range(3), $urandom, $urandom,
                     $urandom, $urandom, 1'b0, $urandom_range(255));
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rows.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_rows.size()));

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
